FILE: rtl/core/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants of the particle pool engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ppe_pkg;

    typedef enum logic [1:0] {
        CMD_EMIT   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // register indexes on the configuration port
    localparam logic [2:0] REG_EMIT_POSITION     = 3'd0;
    localparam logic [2:0] REG_EMIT_VELOCITY     = 3'd1;
    localparam logic [2:0] REG_VELOCITY_SPREAD   = 3'd2;
    localparam logic [2:0] REG_COLOR_START       = 3'd3;
    localparam logic [2:0] REG_COLOR_FINISH      = 3'd4;
    localparam logic [2:0] REG_SIZE_RANGE        = 3'd5;
    localparam logic [2:0] REG_SIZE_SPREAD_SCALE = 3'd6;
    localparam logic [2:0] REG_LIFE_SPAN         = 3'd7;

    localparam logic [31:0] COLOR_START_RST       = 32'hFFFF_FFFF;
    localparam logic [31:0] SIZE_SPREAD_SCALE_RST = 32'h0100_0000;
    localparam logic [15:0] LIFE_SPAN_RST         = 16'h0100;

    localparam int unsigned DIV_STEPS = 16;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  slot;
        logic [15:0] time_step;
        logic [15:0] rand_angle;
        logic [15:0] rand_vel_x;
        logic [15:0] rand_vel_y;
        logic [15:0] rand_size;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         slot_used;
        logic               alive;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        angle;
        logic [15:0]        quad_size;
        logic [31:0]        quad_color;
    } t_out_item;

    typedef struct packed {
        logic [31:0] emit_position;
        logic [31:0] emit_velocity;
        logic [31:0] velocity_spread;
        logic [31:0] color_start;
        logic [31:0] color_finish;
        logic [31:0] size_range;
        logic [31:0] size_spread_scale;
        logic [15:0] life_span;
    } t_cfg;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] velocity;
        logic [15:0] rotation;
        logic [15:0] life_left;
        logic [15:0] life_total;
        logic [15:0] size_begin;
        logic [15:0] size_end;
        logic [15:0] size_scale;
        logic [31:0] color_begin;
        logic [31:0] color_end;
    } t_slot;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic mem_read;
        logic calc;
        logic div_step;
        logic lerp;
        logic scale;
        logic write;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic hit;
        logic out_free;
        t_cmd cmd;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/core/ppe_if.sv
// ----------------------------------------------------------------------------
// ppe_if
// Valid/ready channels carrying command beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppe_in_if;
    logic              valid;
    logic              ready;
    ppe_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ppe_out_if;
    logic               valid;
    logic               ready;
    ppe_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ppe_ctrl.sv
// ----------------------------------------------------------------------------
// ppe_ctrl
// Sequencer: clearing pass, slot read, compute, divide, blend, scale, write back, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  ppe_pkg::t_dp_stat   i_stat,
    output ppe_pkg::t_ctrl_cmd  o_ctl
);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_READ  = 9'b000000100,
        S_CALC  = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_LERP  = 9'b000100000,
        S_SCALE = 9'b001000000,
        S_WRITE = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_ctl.mem_read = 1'b1;
                n_state        = S_CALC;
            end
            S_CALC: begin
                o_ctl.calc = 1'b1;
                if (i_stat.cmd == ppe_pkg::CMD_EMIT) begin
                    n_state = S_WRITE;
                end else if (i_stat.cmd == ppe_pkg::CMD_UPDATE && i_stat.hit) begin
                    n_state = S_WRITE;
                end else if (i_stat.cmd == ppe_pkg::CMD_RENDER && i_stat.hit) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_LERP;
                end
            end
            S_LERP: begin
                o_ctl.lerp = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_ctl.scale = 1'b1;
                n_state     = S_OUT;
            end
            S_WRITE: begin
                o_ctl.write = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/ppe_datapath.sv
// ----------------------------------------------------------------------------
// ppe_datapath
// Slot memories, emit/update arithmetic, life divider, blend and result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_datapath #(
    parameter int unsigned POOL_SLOTS = 1024,
    parameter int unsigned SPIN_RATE  = 104
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ppe_pkg::t_cfg       i_cfg,
    input  ppe_pkg::t_ctrl_cmd  i_ctl,
    output ppe_pkg::t_dp_stat   o_stat,
    input  ppe_pkg::t_in_item   i_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output ppe_pkg::t_out_item  o_out_item
);

    localparam int unsigned IW = $clog2(POOL_SLOTS);
    localparam logic [IW-1:0] TOP_SLOT = IW'(POOL_SLOTS - 1);

    function automatic logic [15:0] sat_s16(input logic signed [33:0] v);
        if (v > 34'sd32767) begin
            return 16'h7FFF;
        end else if (v < -34'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] sat_u16(input logic signed [33:0] v);
        if (v > 34'sd65535) begin
            return 16'hFFFF;
        end else if (v < 34'sd0) begin
            return 16'h0000;
        end
        return v[15:0];
    endfunction

    // base + floor(spread * (r - 0.5)), both in 16 bits
    function automatic logic signed [33:0] spread_sum(input logic [15:0] base,
                                                      input logic        base_signed,
                                                      input logic [15:0] spread,
                                                      input logic [15:0] r);
        logic signed [16:0] rc;
        logic signed [33:0] prod;
        logic signed [33:0] b;
        rc   = $signed({1'b0, r}) - 17'sd32768;
        prod = $signed({1'b0, spread}) * rc;
        b    = base_signed ? 34'($signed(base)) : $signed({18'd0, base});
        return b + (prod >>> 16);
    endfunction

    // (end*(1-f) + begin*f), rounded, f in Q1.16 up to 1.0
    function automatic logic [15:0] lerp16(input logic [15:0] e,
                                           input logic [15:0] b,
                                           input logic [16:0] f);
        logic signed [16:0] d;
        logic signed [35:0] prod;
        logic signed [35:0] acc;
        d    = $signed({1'b0, b}) - $signed({1'b0, e});
        prod = d * $signed({1'b0, f});
        acc  = $signed({4'd0, e, 16'd0}) + prod + 36'sd32768;
        return acc[31:16];
    endfunction

    ppe_pkg::t_in_item r_item;
    logic [IW-1:0]     r_idx, r_wr_idx, r_clr_cnt;
    logic              r_valid;

    ppe_pkg::t_slot    r_mem [POOL_SLOTS];
    logic              r_flag [POOL_SLOTS];
    ppe_pkg::t_slot    r_rd;
    logic              r_flag_rd;

    ppe_pkg::t_slot    r_new, n_new;
    logic              r_new_flag, n_new_flag;

    logic [16:0]       r_rem;
    logic [15:0]       r_q;
    logic [4:0]        r_dcnt;
    logic [16:0]       rem2;
    logic [16:0]       f_val;

    logic [31:0]       r_lc;
    logic [15:0]       r_ls, r_qs;
    logic [32:0]       scaled;

    logic              r_out_valid;
    ppe_pkg::t_out_item r_out, n_out;
    logic              hit, alive;
    ppe_pkg::t_slot    src;

    assign hit = r_valid & r_flag_rd;

    assign o_stat.clear_done = (r_clr_cnt == TOP_SLOT);
    assign o_stat.div_done   = (r_dcnt == 5'd0);
    assign o_stat.hit        = hit;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.cmd        = ppe_pkg::t_cmd'(r_item.command);

    // command capture and ring index
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_item  <= i_item;
            r_valid <= ({7'd0, i_item.slot} < 17'(POOL_SLOTS));
            if (i_item.command == ppe_pkg::CMD_EMIT) begin
                r_idx <= r_wr_idx;
            end else begin
                r_idx <= IW'(i_item.slot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= TOP_SLOT;
            r_clr_cnt <= '0;
        end else begin
            if (i_ctl.clear_step && r_clr_cnt != TOP_SLOT) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_ctl.write && r_item.command == ppe_pkg::CMD_EMIT) begin
                r_wr_idx <= (r_wr_idx == '0) ? TOP_SLOT : r_wr_idx - 1'b1;
            end
        end
    end

    // slot store and active flags
    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_mem[r_idx] <= r_new;
        end
        if (i_ctl.mem_read) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear_step) begin
            r_flag[r_clr_cnt] <= 1'b0;
        end else if (i_ctl.write) begin
            r_flag[r_idx] <= r_new_flag;
        end
        if (i_ctl.mem_read) begin
            r_flag_rd <= r_flag[r_idx];
        end
    end

    // emit and update arithmetic
    always_comb begin
        logic signed [32:0] mvx, mvy;
        logic [31:0]        spin;
        n_new      = r_rd;
        n_new_flag = 1'b1;
        mvx  = $signed(r_rd.velocity[15:0]) * $signed({1'b0, r_item.time_step});
        mvy  = $signed(r_rd.velocity[31:16]) * $signed({1'b0, r_item.time_step});
        spin = 16'(SPIN_RATE) * r_item.time_step;
        if (r_item.command == ppe_pkg::CMD_EMIT) begin
            n_new.position    = i_cfg.emit_position;
            n_new.rotation    = r_item.rand_angle;
            n_new.velocity    = {
                sat_s16(spread_sum(i_cfg.emit_velocity[31:16], 1'b1,
                                   i_cfg.velocity_spread[31:16], r_item.rand_vel_y)),
                sat_s16(spread_sum(i_cfg.emit_velocity[15:0], 1'b1,
                                   i_cfg.velocity_spread[15:0], r_item.rand_vel_x))};
            n_new.color_begin = i_cfg.color_start;
            n_new.color_end   = i_cfg.color_finish;
            n_new.life_left   = i_cfg.life_span;
            n_new.life_total  = i_cfg.life_span;
            n_new.size_begin  = sat_u16(spread_sum(i_cfg.size_range[15:0], 1'b0,
                                                   i_cfg.size_spread_scale[15:0],
                                                   r_item.rand_size));
            n_new.size_end    = i_cfg.size_range[31:16];
            n_new.size_scale  = i_cfg.size_spread_scale[31:16];
        end else if (r_rd.life_left == 16'd0) begin
            // spent slot retires on this update
            n_new_flag = 1'b0;
        end else begin
            n_new.position = {
                sat_s16(34'($signed(r_rd.position[31:16])) + 34'(mvy >>> 8)),
                sat_s16(34'($signed(r_rd.position[15:0])) + 34'(mvx >>> 8))};
            n_new.rotation  = r_rd.rotation + spin[23:8];
            n_new.life_left = (r_rd.life_left > r_item.time_step) ?
                              r_rd.life_left - r_item.time_step : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            r_new      <= n_new;
            r_new_flag <= n_new_flag;
        end
    end

    // life fraction divider, one quotient bit a cycle
    assign rem2 = {r_rem[15:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_ctl.calc) begin
            r_dcnt <= 5'(ppe_pkg::DIV_STEPS);
        end else if (i_ctl.div_step && r_dcnt != 5'd0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            r_rem <= {1'b0, r_rd.life_left};
            r_q   <= '0;
        end else if (i_ctl.div_step && r_dcnt != 5'd0) begin
            if (rem2 >= {1'b0, r_rd.life_total}) begin
                r_rem <= rem2 - {1'b0, r_rd.life_total};
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_q   <= {r_q[14:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_rd.life_total == 16'd0) begin
            f_val = 17'd0;
        end else if (r_rd.life_left >= r_rd.life_total) begin
            f_val = 17'h10000;
        end else begin
            f_val = {1'b0, r_q};
        end
    end

    // blend and scale
    assign scaled = ({17'd0, r_ls} * {17'd0, r_rd.size_scale}) + 33'd128;

    always_ff @(posedge i_clk) begin
        if (i_ctl.lerp) begin
            for (int k = 0; k < 4; k++) begin
                r_lc[8*k +: 8] <= 8'(lerp16({8'd0, r_rd.color_end[8*k +: 8]},
                                            {8'd0, r_rd.color_begin[8*k +: 8]}, f_val));
            end
            r_ls <= lerp16(r_rd.size_end, r_rd.size_begin, f_val);
        end
        if (i_ctl.scale) begin
            r_qs <= (scaled[32:24] != 9'd0) ? 16'hFFFF : scaled[23:8];
        end
    end

    // result beat
    always_comb begin
        case (ppe_pkg::t_cmd'(r_item.command))
            ppe_pkg::CMD_EMIT:   alive = 1'b1;
            ppe_pkg::CMD_UPDATE: alive = hit && (r_rd.life_left != 16'd0);
            ppe_pkg::CMD_RENDER: alive = hit;
            default:             alive = hit;
        endcase
        src = (r_item.command == ppe_pkg::CMD_RENDER) ? r_rd : r_new;
        n_out            = '0;
        n_out.alive      = alive;
        n_out.slot_used  = (r_item.command == ppe_pkg::CMD_EMIT) ? 10'(r_idx) : r_item.slot;
        if (alive && r_item.command != ppe_pkg::CMD_NOP) begin
            n_out.pos_x = $signed(src.position[15:0]);
            n_out.pos_y = $signed(src.position[31:16]);
            n_out.angle = src.rotation;
            if (r_item.command == ppe_pkg::CMD_RENDER) begin
                n_out.quad_size  = r_qs;
                n_out.quad_color = r_lc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/particle_pool_engine_core.sv
// ----------------------------------------------------------------------------
// particle_pool_engine_core
// Ring pool of particle slots with emit, update and render commands.
// ----------------------------------------------------------------------------
// Command beats arrive on i_in (valid/ready) and each gives exactly one
// result beat on o_out (valid/ready). Emitter settings are to be written
// over the APB port only while the block is idle; the block itself does
// not enforce this, and pready is always high. One command is worked at a
// time. Emit and update of an active slot go through slot read, compute,
// write back and result load; other commands skip the write back. Render
// of an active slot runs the 16-step restoring divider that forms remaining
// life over lifetime, followed by a blend and a scale stage.
// After reset a clearing pass sweeps the active flags, one slot a cycle,
// and i_in.ready stays low until it completes.
// Results sit in an output register; a new command is accepted while a
// result waits, but the next result is held in the datapath until the
// receiver takes the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_engine_core #(
    parameter int unsigned POOL_SLOTS = 1024,
    parameter int unsigned SPIN_RATE  = 104
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ppe_in_if.sink       i_in,
    ppe_out_if.source    o_out,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    ppe_pkg::t_cfg      r_cfg;
    ppe_pkg::t_ctrl_cmd ctl;
    ppe_pkg::t_dp_stat  stat;
    logic               in_ready;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.emit_position     <= '0;
            r_cfg.emit_velocity     <= '0;
            r_cfg.velocity_spread   <= '0;
            r_cfg.color_start       <= ppe_pkg::COLOR_START_RST;
            r_cfg.color_finish      <= '0;
            r_cfg.size_range        <= '0;
            r_cfg.size_spread_scale <= ppe_pkg::SIZE_SPREAD_SCALE_RST;
            r_cfg.life_span         <= ppe_pkg::LIFE_SPAN_RST;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                ppe_pkg::REG_EMIT_POSITION:     r_cfg.emit_position     <= pwdata;
                ppe_pkg::REG_EMIT_VELOCITY:     r_cfg.emit_velocity     <= pwdata;
                ppe_pkg::REG_VELOCITY_SPREAD:   r_cfg.velocity_spread   <= pwdata;
                ppe_pkg::REG_COLOR_START:       r_cfg.color_start       <= pwdata;
                ppe_pkg::REG_COLOR_FINISH:      r_cfg.color_finish      <= pwdata;
                ppe_pkg::REG_SIZE_RANGE:        r_cfg.size_range        <= pwdata;
                ppe_pkg::REG_SIZE_SPREAD_SCALE: r_cfg.size_spread_scale <= pwdata;
                ppe_pkg::REG_LIFE_SPAN:         r_cfg.life_span         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            ppe_pkg::REG_EMIT_POSITION:     prdata = r_cfg.emit_position;
            ppe_pkg::REG_EMIT_VELOCITY:     prdata = r_cfg.emit_velocity;
            ppe_pkg::REG_VELOCITY_SPREAD:   prdata = r_cfg.velocity_spread;
            ppe_pkg::REG_COLOR_START:       prdata = r_cfg.color_start;
            ppe_pkg::REG_COLOR_FINISH:      prdata = r_cfg.color_finish;
            ppe_pkg::REG_SIZE_RANGE:        prdata = r_cfg.size_range;
            ppe_pkg::REG_SIZE_SPREAD_SCALE: prdata = r_cfg.size_spread_scale;
            ppe_pkg::REG_LIFE_SPAN:         prdata = {16'd0, r_cfg.life_span};
            default:                        prdata = '0;
        endcase
    end

    assign i_in.ready = in_ready;

    ppe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    ppe_datapath #(
        .POOL_SLOTS (POOL_SLOTS),
        .SPIN_RATE  (SPIN_RATE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_item      (i_in.payload),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (o_out.payload)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ppe_checker.sv
// ----------------------------------------------------------------------------
// ppe_checker
// Port-level checks of the particle pool engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 i_in_ready,
    input wire                 i_out_valid,
    input wire                 i_out_ready,
    input ppe_pkg::t_out_item  i_out_item,
    input wire                 i_pready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result beat changed while stalled");

    // one command in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second command taken while busy");

    // dead slots report no data
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.alive |->
            i_out_item.pos_x == 16'sd0 && i_out_item.pos_y == 16'sd0 &&
            i_out_item.angle == 16'd0 && i_out_item.quad_size == 16'd0 &&
            i_out_item.quad_color == 32'd0)
        else $error("data on a dead slot");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready dropped");

endmodule

bind particle_pool_engine_core ppe_checker u_ppe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload),
    .i_pready    (pready)
);

`default_nettype wire

FILE: test/ppe_result_checker.sv
// ----------------------------------------------------------------------------
// ppe_result_checker
// Watches the command and result channels and the register port, keeps a
// private copy of the particle pool, predicts the result of every accepted
// command and compares it field by field with the result beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppe_result_checker
    import ppe_pkg::*;
#(
    parameter int unsigned POOL_SLOTS = 1024,
    parameter int unsigned SPIN_RATE  = 104
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ppe_in_if           i_in,
    ppe_out_if          i_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          o_fail_count,
    output int          o_pending
);

    t_cfg        settings;
    bit          slot_active [POOL_SLOTS];
    t_slot       pool        [POOL_SLOTS];
    logic [9:0]  emit_ptr;
    t_out_item   expected_results [$];

    function automatic logic [15:0] clamp_s16(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] clamp_u16(longint v);
        if (v > 65535) return 16'hffff;
        if (v < 0) return 16'h0000;
        return v[15:0];
    endfunction

    function automatic longint blend(longint e, longint b, longint f);
        return (e * (65536 - f) + b * f + 32768) >>> 16;
    endfunction

    // base plus spread times a centered random fraction, floor division
    function automatic logic [15:0] spread_add(logic [15:0] base, logic [15:0] spread,
                                               logic [15:0] r);
        return clamp_s16(longint'($signed(base)) +
                         ((longint'(spread) * (longint'(r) - 32768)) >>> 16));
    endfunction

    task automatic predict_particle(input t_in_item it, output t_out_item res);
        logic [9:0]  w;
        logic [15:0] px, py;
        longint      f, s;
        t_slot       sl;
        res = '0;
        res.slot_used = it.slot;
        if (t_cmd'(it.command) == CMD_EMIT) begin
            w = emit_ptr;
            sl.position    = settings.emit_position;
            sl.rotation    = it.rand_angle;
            sl.velocity    = {spread_add(settings.emit_velocity[31:16],
                                         settings.velocity_spread[31:16], it.rand_vel_y),
                              spread_add(settings.emit_velocity[15:0],
                                         settings.velocity_spread[15:0], it.rand_vel_x)};
            sl.color_begin = settings.color_start;
            sl.color_end   = settings.color_finish;
            sl.life_left   = settings.life_span;
            sl.life_total  = settings.life_span;
            sl.size_begin  = clamp_u16(longint'(settings.size_range[15:0]) +
                                 ((longint'(settings.size_spread_scale[15:0]) *
                                   (longint'(it.rand_size) - 32768)) >>> 16));
            sl.size_end    = settings.size_range[31:16];
            sl.size_scale  = settings.size_spread_scale[31:16];
            pool[w] = sl;
            slot_active[w] = 1'b1;
            emit_ptr = (w == 0) ? 10'(POOL_SLOTS - 1) : w - 1'b1;
            res.slot_used = w;
            res.alive = 1'b1;
            res.pos_x = sl.position[15:0];
            res.pos_y = sl.position[31:16];
            res.angle = sl.rotation;
        end else if (t_cmd'(it.command) == CMD_NOP) begin
            res.alive = slot_active[it.slot];
        end else if (slot_active[it.slot]) begin
            sl = pool[it.slot];
            res.alive = 1'b1;
            if (t_cmd'(it.command) == CMD_UPDATE) begin
                if (sl.life_left == 0) begin
                    slot_active[it.slot] = 1'b0;
                    res.alive = 1'b0;
                end else begin
                    px = clamp_s16(longint'($signed(sl.position[15:0])) +
                         ((longint'($signed(sl.velocity[15:0])) * longint'(it.time_step)) >>> 8));
                    py = clamp_s16(longint'($signed(sl.position[31:16])) +
                         ((longint'($signed(sl.velocity[31:16])) * longint'(it.time_step)) >>> 8));
                    sl.position = {py, px};
                    sl.rotation = sl.rotation + 16'((longint'(SPIN_RATE) * it.time_step) >> 8);
                    sl.life_left = (sl.life_left > it.time_step) ? sl.life_left - it.time_step
                                                                 : 16'd0;
                    pool[it.slot] = sl;
                end
            end else begin
                f = 0;
                if (sl.life_total != 0) begin
                    f = (longint'(sl.life_left) << 16) / longint'(sl.life_total);
                    if (f > 65536) f = 65536;
                end
                for (int k = 0; k < 4; k++)
                    res.quad_color[8*k +: 8] = 8'(blend(sl.color_end[8*k +: 8],
                                                        sl.color_begin[8*k +: 8], f));
                s = blend(sl.size_end, sl.size_begin, f);
                res.quad_size = clamp_u16((s * longint'(sl.size_scale) + 128) >>> 8);
            end
            if (res.alive) begin
                res.pos_x = sl.position[15:0];
                res.pos_y = sl.position[31:16];
                res.angle = sl.rotation;
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_r, got;
        if (!i_rst_n) begin
            settings <= '{emit_position: '0, emit_velocity: '0, velocity_spread: '0,
                          color_start: COLOR_START_RST, color_finish: '0, size_range: '0,
                          size_spread_scale: SIZE_SPREAD_SCALE_RST,
                          life_span: LIFE_SPAN_RST};
            for (int i = 0; i < POOL_SLOTS; i++) slot_active[i] = 1'b0;
            emit_ptr = 10'(POOL_SLOTS - 1);
            expected_results.delete();
            o_pending = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_EMIT_POSITION:     settings.emit_position     <= pwdata;
                    REG_EMIT_VELOCITY:     settings.emit_velocity     <= pwdata;
                    REG_VELOCITY_SPREAD:   settings.velocity_spread   <= pwdata;
                    REG_COLOR_START:       settings.color_start       <= pwdata;
                    REG_COLOR_FINISH:      settings.color_finish      <= pwdata;
                    REG_SIZE_RANGE:        settings.size_range        <= pwdata;
                    REG_SIZE_SPREAD_SCALE: settings.size_spread_scale <= pwdata;
                    REG_LIFE_SPAN:         settings.life_span         <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got = i_out.payload;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing outstanding: %h", got);
                    o_fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("slot_used", exp_r.slot_used, got.slot_used);
                    check_field("alive", exp_r.alive, got.alive);
                    check_field("pos_x", exp_r.pos_x, got.pos_x);
                    check_field("pos_y", exp_r.pos_y, got.pos_y);
                    check_field("angle", exp_r.angle, got.angle);
                    check_field("quad_size", exp_r.quad_size, got.quad_size);
                    check_field("quad_color", exp_r.quad_color, got.quad_color);
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_particle(i_in.payload, exp_r);
                expected_results.push_back(exp_r);
            end
            o_pending = expected_results.size();
        end
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

endmodule

FILE: test/tb_particle_pool_engine_core.sv
// ----------------------------------------------------------------------------
// tb_particle_pool_engine_core
// Drives emit, update, render and unused commands with random idling on both
// channels and register writes between phases; the result checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_particle_pool_engine_core;
    import ppe_pkg::*;

    localparam int unsigned POOL_SLOTS = 1024;
    localparam int          CYCLE_LIMIT = 800000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    int          fail_count, pending;

    int          idle_pct = 0, stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          cycle_count = 0;
    logic [9:0]  next_emit = 10'(POOL_SLOTS - 1);

    ppe_in_if  cmd_ch ();
    ppe_out_if res_ch ();

    particle_pool_engine_core dut (
        .i_clk, .i_rst_n, .i_in(cmd_ch), .o_out(res_ch),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    ppe_result_checker chk (
        .i_clk, .i_rst_n, .i_in(cmd_ch), .i_out(res_ch),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready = 1'b0;
        end else begin
            res_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_in_item make_item(t_cmd c, logic [9:0] s, logic [15:0] ts);
        t_in_item it;
        it.command    = c;
        it.slot       = s;
        it.time_step  = ts;
        it.rand_angle = 16'($urandom);
        it.rand_vel_x = 16'($urandom);
        it.rand_vel_y = 16'($urandom);
        it.rand_size  = 16'($urandom);
        return it;
    endfunction

    task automatic send_beat(t_in_item it);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.payload = it;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (t_cmd'(it.command) == CMD_EMIT) begin
            next_emit = (next_emit == 0) ? 10'(POOL_SLOTS - 1) : next_emit - 1'b1;
        end
    endtask

    task automatic send_cmd(t_cmd c, logic [9:0] s, logic [15:0] ts);
        send_beat(make_item(c, s, ts));
    endtask

    task automatic wait_quiet();
        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_settings();
        logic [15:0] life;
        wait_quiet();
        reg_write(REG_EMIT_POSITION, pick_word());
        reg_write(REG_EMIT_VELOCITY, pick_word());
        reg_write(REG_VELOCITY_SPREAD, pick_word());
        reg_write(REG_COLOR_START, pick_word());
        reg_write(REG_COLOR_FINISH, pick_word());
        reg_write(REG_SIZE_RANGE, pick_word());
        reg_write(REG_SIZE_SPREAD_SCALE, pick_word());
        case ($urandom_range(5))
            0: life = 16'd1;
            1: life = 16'hffff;
            2: life = 16'($urandom_range(2, 64));
            3: life = 16'd256;
            default: life = 16'($urandom_range(16, 2048));
        endcase
        reg_write(REG_LIFE_SPAN, {16'h0, life});
    endtask

    // mostly emit/update/render on recently written slots, some noise
    task automatic random_beat();
        int          p;
        logic [9:0]  s;
        logic [15:0] ts;
        t_in_item    it;
        p = $urandom_range(99);
        if ($urandom_range(4) != 0)
            s = next_emit + 10'd1 + 10'($urandom_range(0, 15));
        else
            s = 10'($urandom);
        case ($urandom_range(9))
            0:       ts = 16'h0000;
            1:       ts = 16'hffff;
            2, 3, 4: ts = 16'($urandom);
            default: ts = 16'($urandom_range(0, 96));
        endcase
        if (p < 40)      it = make_item(CMD_EMIT, 10'($urandom), ts);
        else if (p < 65) it = make_item(CMD_UPDATE, s, ts);
        else if (p < 90) it = make_item(CMD_RENDER, s, ts);
        else if (p < 95) it = make_item(CMD_NOP, s, ts);
        else begin
            it = make_item(CMD_EMIT, 10'($urandom), 16'($urandom));
            it.command = 2'($urandom);
        end
        send_beat(it);
    endtask

    initial begin
        t_in_item it;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // extreme settings, short life so slots die quickly
        reg_write(REG_EMIT_POSITION, 32'h7fff_8000);
        reg_write(REG_EMIT_VELOCITY, 32'h8000_7fff);
        reg_write(REG_VELOCITY_SPREAD, 32'hffff_ffff);
        reg_write(REG_COLOR_START, 32'h00ff_ff00);
        reg_write(REG_COLOR_FINISH, 32'hff00_00ff);
        reg_write(REG_SIZE_RANGE, 32'hffff_0000);
        reg_write(REG_SIZE_SPREAD_SCALE, 32'hffff_ffff);
        reg_write(REG_LIFE_SPAN, 32'h0000_0003);

        it = make_item(CMD_EMIT, 10'h3ff, 16'h0);
        it.rand_angle = '0; it.rand_vel_x = '0; it.rand_vel_y = '0; it.rand_size = '0;
        send_beat(it);
        it.rand_angle = '1; it.rand_vel_x = '1; it.rand_vel_y = '1; it.rand_size = '1;
        send_beat(it);
        it.rand_vel_x = 16'h8000; it.rand_vel_y = 16'h8000; it.rand_size = 16'h8000;
        send_beat(it);
        send_cmd(CMD_UPDATE, 10'd1023, 16'h0000);
        send_cmd(CMD_RENDER, 10'd1023, 16'h0000);
        send_cmd(CMD_UPDATE, 10'd1023, 16'hffff);   // saturates, life to zero
        send_cmd(CMD_RENDER, 10'd1023, 16'h0000);
        send_cmd(CMD_UPDATE, 10'd1023, 16'h0001);   // dead slot is cleared
        send_cmd(CMD_UPDATE, 10'd1023, 16'h0001);
        send_cmd(CMD_RENDER, 10'd1023, 16'h0000);
        send_cmd(CMD_UPDATE, 10'd1022, 16'h0001);
        send_cmd(CMD_RENDER, 10'd1022, 16'hffff);
        send_cmd(CMD_NOP, 10'd1022, 16'h0000);
        send_cmd(CMD_NOP, 10'd0, 16'h0000);
        send_cmd(CMD_UPDATE, 10'd0, 16'h0010);
        send_cmd(CMD_RENDER, 10'd0, 16'h0010);

        // zero lifetime
        wait_quiet();
        reg_write(REG_LIFE_SPAN, 32'h0000_0000);
        send_cmd(CMD_EMIT, 10'd0, 16'h0);
        send_cmd(CMD_RENDER, next_emit + 10'd1, 16'h0);
        send_cmd(CMD_UPDATE, next_emit + 10'd1, 16'h5);

        for (int ph = 0; ph < 4; ph++) begin
            random_settings();
            idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 24 : 0;
            stall_pct = (ph == 2) ? 62 : (ph == 3) ? 24 : 0;
            for (int n = 0; n < 235; n++) begin
                if (ph == 0 && n == 100) hold_req = 1'b1;
                random_beat();
            end
        end

        idle_pct = 0;
        stall_pct = 0;
        send_cmd(CMD_RENDER, next_emit + 10'd1, 16'h0);
        send_cmd(CMD_UPDATE, next_emit + 10'd2, 16'h3);

        wait_quiet();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
